### design/sdm_pkg.sv
// Shared constants and types for the second difference map block.
`default_nettype none

package sdm_pkg;

	// Field widths of the request payloads
	localparam int PIXEL_W = 16;
	localparam int DIFF_W  = 18;
	localparam int ROW_W   = 10;
	localparam int COL_W   = 10;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t REG_IMAGE_WIDTH   = 2'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT  = 2'd1;
	localparam cfg_index_t REG_NEIGHBOR_DIST = 2'd2;
	localparam cfg_index_t REG_PICK_STRONGER = 2'd3;

	// Register reset values
	localparam int RST_IMAGE_WIDTH   = 640;
	localparam int RST_IMAGE_HEIGHT  = 480;
	localparam int RST_NEIGHBOR_DIST = 1;

	// Default sizing of the block
	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_HEIGHT   = 1024;
	localparam int DEF_MAX_DISTANCE = 8;

	typedef logic [PIXEL_W-1:0]       pixel_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [COL_W-1:0]         col_t;

endpackage

`default_nettype wire

### design/sdm_if.sv
// Valid/ready channel interfaces for pixel requests and result requests.
`default_nettype none

interface sdm_pixel_if;
	import sdm_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface sdm_result_if;
	import sdm_pkg::*;

	logic  valid;
	logic  ready;
	diff_t difference;
	row_t  out_row;
	col_t  out_col;
	logic  frame_last;

	modport source (output valid, output difference, output out_row, output out_col,
		output frame_last, input ready);
	modport sink (input valid, input difference, input out_row, input out_col,
		input frame_last, output ready);
endinterface

`default_nettype wire

### design/sdm_line_mem.sv
// Line store memory: one write port, two registered read ports, read-first.
`default_nettype none

module sdm_line_mem #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [DATA_W-1:0] rdata_a,
	output logic      [DATA_W-1:0] rdata_b
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	// Reads return the contents from before a write in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

### design/second_difference_map_core.sv
// Top level of the streaming second difference stencil filter.
`default_nettype none

// Takes one pixel per clock in raster order unless the output stalls and,
// once distance rows are in, returns one result per pixel for the pixel
// distance rows above it: the vertical or horizontal second difference,
// whichever is weaker (or stronger, if pick_stronger is set), zero within
// distance of a border. Results pass the s1, s2 and output registers. The
// rate is set by the two copies of the line store, each taking one pixel
// write and two neighbor reads per pixel. The line store has no clearing
// pass and is usable right after reset; each copy holds 2*MAX_DISTANCE
// lines of MAX_WIDTH (rounded up to a power of two) pixels. Configuration
// must be written only while no pixel is in flight (not enforced).
module second_difference_map_core #(
	parameter int MAX_WIDTH    = sdm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = sdm_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_DISTANCE = sdm_pkg::DEF_MAX_DISTANCE
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire sdm_pkg::cfg_index_t cfg_index,
	input  wire sdm_pkg::cfg_data_t  cfg_data,
	sdm_pixel_if.sink               pixel_ch,
	sdm_result_if.source            result_ch
);
	import sdm_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DW    = $clog2(MAX_DISTANCE + 1);
	localparam int LINES = 2 * MAX_DISTANCE;
	localparam int SW    = $clog2(LINES);
	localparam int AW    = SW + CW;

	localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
	localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
	localparam int RST_D = (RST_NEIGHBOR_DIST > MAX_DISTANCE) ? MAX_DISTANCE :
		RST_NEIGHBOR_DIST;

	// Configuration, held in clamped form
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [DW-1:0] dist_q;
	logic          pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
			dist_q   <= DW'(RST_D);
			pick_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (cfg_data == '0)
						width_q <= WW'(1);
					else if (32'(cfg_data) > 32'(MAX_WIDTH))
						width_q <= WW'(MAX_WIDTH);
					else
						width_q <= WW'(cfg_data);
				end
				REG_IMAGE_HEIGHT: begin
					if (cfg_data == '0)
						height_q <= HW'(1);
					else if (32'(cfg_data) > 32'(MAX_HEIGHT))
						height_q <= HW'(MAX_HEIGHT);
					else
						height_q <= HW'(cfg_data);
				end
				REG_NEIGHBOR_DIST: begin
					if (32'(cfg_data[3:0]) > 32'(MAX_DISTANCE))
						dist_q <= DW'(MAX_DISTANCE);
					else
						dist_q <= DW'(cfg_data[3:0]);
				end
				REG_PICK_STRONGER: begin
					pick_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline enables: each stage moves when the one after it moves or is empty
	logic v_s1, v_s2, out_v_q;
	logic en_out, en_s2, en_s1, accept;

	assign en_out         = !out_v_q || result_ch.ready;
	assign en_s2          = en_out || !v_s2;
	assign en_s1          = en_s2 || !v_s1;
	assign pixel_ch.ready = en_s1;
	assign accept         = pixel_ch.valid && en_s1;

	// Raster position of the next pixel and its line slot
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] slot_q;

	logic          emit, in_bounds, last, col_wrap, row_wrap;
	logic [31:0]   slot_c_sum, slot_u_sum;
	logic [SW-1:0] slot_c, slot_u;
	logic [CW-1:0] col_left, col_right;

	always_comb begin
		emit      = 32'(row_q) >= 32'(dist_q);
		in_bounds = (32'(row_q) >= 32'(2 * dist_q)) && (32'(col_q) >= 32'(dist_q)) &&
			(32'(col_q) + 32'(dist_q) < 32'(width_q));
		col_wrap  = 32'(col_q) + 32'd1 >= 32'(width_q);
		row_wrap  = 32'(row_q) + 32'd1 >= 32'(height_q);
		last      = col_wrap && row_wrap;

		// Slots of the center line and of the line above it, modulo LINES
		slot_c_sum = 32'(slot_q) + 32'(LINES) - 32'(dist_q);
		if (slot_c_sum >= 32'(LINES))
			slot_c_sum = slot_c_sum - 32'(LINES);
		slot_u_sum = 32'(slot_q) + 32'(LINES) - 32'(2 * dist_q);
		if (slot_u_sum >= 32'(LINES))
			slot_u_sum = slot_u_sum - 32'(LINES);
		slot_c = SW'(slot_c_sum);
		slot_u = SW'(slot_u_sum);

		col_left  = CW'(32'(col_q) - 32'(dist_q));
		col_right = CW'(32'(col_q) + 32'(dist_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + RW'(1);
					slot_q <= (32'(slot_q) == LINES - 1) ? '0 : slot_q + SW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Two copies of the line store: center and up at column c; left and right
	pixel_t center_s1, up_s1, left_s1, right_s1;

	sdm_line_mem #(
		.ADDR_W (AW),
		.DATA_W (PIXEL_W)
	) u_mem_vert (
		.clk     (clk),
		.we      (accept),
		.waddr   ({slot_q, col_q}),
		.wdata   (pixel_ch.pixel),
		.re      (en_s1),
		.raddr_a ({slot_c, col_q}),
		.raddr_b ({slot_u, col_q}),
		.rdata_a (center_s1),
		.rdata_b (up_s1)
	);

	sdm_line_mem #(
		.ADDR_W (AW),
		.DATA_W (PIXEL_W)
	) u_mem_horz (
		.clk     (clk),
		.we      (accept),
		.waddr   ({slot_q, col_q}),
		.wdata   (pixel_ch.pixel),
		.re      (en_s1),
		.raddr_a ({slot_c, col_left}),
		.raddr_b ({slot_c, col_right}),
		.rdata_a (left_s1),
		.rdata_b (right_s1)
	);

	// Stage 1: request fields alongside the memory reads
	pixel_t px_s1;
	row_t   row_s1;
	col_t   col_s1;
	logic   in_bounds_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= accept && emit;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1        <= pixel_ch.pixel;
			row_s1       <= ROW_W'(32'(row_q) - 32'(dist_q));
			col_s1       <= COL_W'(col_q);
			in_bounds_s1 <= in_bounds;
			last_s1      <= last;
		end
	end

	// Both second differences
	logic signed [DIFF_W:0] vert_sum, hori_sum;

	always_comb begin
		vert_sum = ($signed({3'b000, center_s1}) <<< 1) - $signed({3'b000, up_s1}) -
			$signed({3'b000, px_s1});
		hori_sum = ($signed({3'b000, center_s1}) <<< 1) - $signed({3'b000, left_s1}) -
			$signed({3'b000, right_s1});
	end

	// Stage 2
	diff_t vert_s2, hori_s2;
	row_t  row_s2;
	col_t  col_s2;
	logic  in_bounds_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			vert_s2      <= vert_sum[DIFF_W-1:0];
			hori_s2      <= hori_sum[DIFF_W-1:0];
			row_s2       <= row_s1;
			col_s2       <= col_s1;
			in_bounds_s2 <= in_bounds_s1;
			last_s2      <= last_s1;
		end
	end

	// Magnitude compare; a tie goes to the horizontal value
	logic [DIFF_W-1:0] mag_v, mag_h;
	diff_t             chosen;

	always_comb begin
		mag_v = vert_s2[DIFF_W-1] ? DIFF_W'(-vert_s2) : DIFF_W'(vert_s2);
		mag_h = hori_s2[DIFF_W-1] ? DIFF_W'(-hori_s2) : DIFF_W'(hori_s2);
		if (!in_bounds_s2)
			chosen = '0;
		else if (pick_q)
			chosen = (mag_v > mag_h) ? vert_s2 : hori_s2;
		else
			chosen = (mag_v < mag_h) ? vert_s2 : hori_s2;
	end

	// Output register
	diff_t diff_q;
	row_t  out_row_q;
	col_t  out_col_q;
	logic  last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en_out)
			out_v_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			diff_q    <= chosen;
			out_row_q <= row_s2;
			out_col_q <= col_s2;
			last_q    <= last_s2;
		end
	end

	assign result_ch.valid      = out_v_q;
	assign result_ch.difference = diff_q;
	assign result_ch.out_row    = out_row_q;
	assign result_ch.out_col    = out_col_q;
	assign result_ch.frame_last = last_q;

endmodule

`default_nettype wire
